### hw/rtl/zora_pkg.sv
// ----------------------------------------------------------------------------
// zora_pkg: shared types and helpers for the Z[omega] ring ALU
// Coefficient width, operation codes, beat structs and width converters.
// ----------------------------------------------------------------------------
package zora_pkg;

    // internal coefficient width; results wrap modulo 2^COEF_W
    localparam int COEF_W = 32;
    // width of coefficients on the ports
    localparam int IO_W   = 32;
    // coefficients per element: a (w^3), b (w^2), c (w), d (1)
    localparam int NCOEF  = 4;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [NCOEF-1:0]        t_elem;   // index 0 = a ... 3 = d
    typedef t_coef [NCOEF-1:0][NCOEF-1:0] t_prod;  // [x index][y index]

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_ADDS  = 3'd3,
        OP_SUBS  = 3'd4,
        OP_SCALE = 3'd5,
        OP_NEG   = 3'd6,
        OP_PASS  = 3'd7
    } t_op;

    // input beat
    typedef struct packed {
        logic        [2:0]      opcode;
        logic signed [IO_W-1:0] x_a;
        logic signed [IO_W-1:0] x_b;
        logic signed [IO_W-1:0] x_c;
        logic signed [IO_W-1:0] x_d;
        logic signed [IO_W-1:0] y_a;
        logic signed [IO_W-1:0] y_b;
        logic signed [IO_W-1:0] y_c;
        logic signed [IO_W-1:0] y_d;
        logic signed [IO_W-1:0] scalar;
    } t_item;

    // result beat
    typedef struct packed {
        logic signed [IO_W-1:0] r_a;
        logic signed [IO_W-1:0] r_b;
        logic signed [IO_W-1:0] r_c;
        logic signed [IO_W-1:0] r_d;
        logic                   x_less;
        logic                   x_equal;
    } t_result;

    // product stage to combine stage
    typedef struct packed {
        t_op   op;
        t_elem x;
        t_elem y;
        t_prod prod;
        logic  less;
        logic  equal;
    } t_mid;

    // port value to internal coefficient (sign-extend or wrap)
    function automatic t_coef f_load(input logic [IO_W-1:0] v);
        return COEF_W'($signed(v));
    endfunction

    // internal coefficient to port value (sign-extend or keep low bits)
    function automatic logic [IO_W-1:0] f_unload(input t_coef c);
        return IO_W'($signed(c));
    endfunction

endpackage

### hw/rtl/zora_prod.sv
// ----------------------------------------------------------------------------
// zora_prod: product stage
// Forms all sixteen coefficient products and the x-versus-y compare flags,
// and registers them with the operands for the combine stage.
// ----------------------------------------------------------------------------
module zora_prod (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  zora_pkg::t_op   i_op,
    input  zora_pkg::t_elem i_x,
    input  zora_pkg::t_elem i_y,
    input  zora_pkg::t_coef i_s,
    output logic            o_vld,
    output zora_pkg::t_mid  o_mid
);

    logic            r_vld;
    zora_pkg::t_mid  r_mid;
    zora_pkg::t_mid  n_mid;
    zora_pkg::t_elem w_b;
    logic [zora_pkg::NCOEF-1:0] w_eq;
    logic [zora_pkg::NCOEF-1:0] w_lt;

    // y operand; the constant slot carries the scalar for the scalar ops
    always_comb begin
        w_b = i_y;
        if (i_op == zora_pkg::OP_SCALE || i_op == zora_pkg::OP_ADDS ||
            i_op == zora_pkg::OP_SUBS) begin
            w_b[zora_pkg::NCOEF-1] = i_s;
        end
    end

    // per-coefficient signed compare
    always_comb begin
        for (int i = 0; i < zora_pkg::NCOEF; i++) begin
            w_eq[i] = (i_x[i] == i_y[i]);
            w_lt[i] = ($signed(i_x[i]) < $signed(i_y[i]));
        end
    end

    // truncated products and lexicographic flags
    always_comb begin
        n_mid.op    = i_op;
        n_mid.x     = i_x;
        n_mid.y     = w_b;
        for (int i = 0; i < zora_pkg::NCOEF; i++) begin
            for (int j = 0; j < zora_pkg::NCOEF; j++) begin
                n_mid.prod[i][j] = i_x[i] * w_b[j];
            end
        end
        n_mid.equal = &w_eq;
        n_mid.less  = w_lt[0]
                    | (w_eq[0] & w_lt[1])
                    | (w_eq[0] & w_eq[1] & w_lt[2])
                    | (w_eq[0] & w_eq[1] & w_eq[2] & w_lt[3]);
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_mid <= n_mid;
    end

    assign o_vld = r_vld;
    assign o_mid = r_mid;

endmodule

### hw/rtl/zora_comb.sv
// ----------------------------------------------------------------------------
// zora_comb: combine stage
// Sums the products into ring-product coefficients, performs the additive
// operations and selects the result by opcode.
// ----------------------------------------------------------------------------
module zora_comb (
    input  zora_pkg::t_mid    i_mid,
    output zora_pkg::t_result o_res
);

    zora_pkg::t_elem w_mul;
    zora_pkg::t_elem w_r;
    zora_pkg::t_prod p;

    assign p = i_mid.prod;

    // product reduced with w^4 = -1
    always_comb begin
        w_mul[0] = p[0][3] + p[1][2] + p[2][1] + p[3][0];
        w_mul[1] = p[1][3] + p[2][2] + p[3][1] - p[0][0];
        w_mul[2] = p[2][3] + p[3][2] - p[0][1] - p[1][0];
        w_mul[3] = p[3][3] - p[0][2] - p[1][1] - p[2][0];
    end

    // result select; scalar lives in the y constant slot of the products
    always_comb begin
        w_r = i_mid.x;
        case (i_mid.op)
            zora_pkg::OP_ADD: begin
                for (int i = 0; i < zora_pkg::NCOEF; i++) w_r[i] = i_mid.x[i] + i_mid.y[i];
            end
            zora_pkg::OP_SUB: begin
                for (int i = 0; i < zora_pkg::NCOEF; i++) w_r[i] = i_mid.x[i] - i_mid.y[i];
            end
            zora_pkg::OP_MUL: begin
                w_r = w_mul;
            end
            zora_pkg::OP_ADDS: begin
                w_r[3] = i_mid.x[3] + i_mid.y[3];
            end
            zora_pkg::OP_SUBS: begin
                w_r[3] = i_mid.x[3] - i_mid.y[3];
            end
            zora_pkg::OP_SCALE: begin
                for (int i = 0; i < zora_pkg::NCOEF; i++) w_r[i] = p[i][3];
            end
            zora_pkg::OP_NEG: begin
                for (int i = 0; i < zora_pkg::NCOEF; i++) w_r[i] = -i_mid.x[i];
            end
            default: begin
                w_r = i_mid.x;
            end
        endcase
    end

    // result beat
    always_comb begin
        o_res.r_a     = zora_pkg::f_unload(w_r[0]);
        o_res.r_b     = zora_pkg::f_unload(w_r[1]);
        o_res.r_c     = zora_pkg::f_unload(w_r[2]);
        o_res.r_d     = zora_pkg::f_unload(w_r[3]);
        o_res.x_less  = i_mid.less;
        o_res.x_equal = i_mid.equal;
    end

endmodule

### hw/rtl/zomega_ring_alu.sv
// ----------------------------------------------------------------------------
// zomega_ring_alu: arithmetic unit over the ring Z[omega], omega^4 = -1
// Add, subtract, multiply, scalar add/subtract/scale and negate on
// four-coefficient elements, plus lexicographic compare of x against y.
// ----------------------------------------------------------------------------
//
// channel | direction | handshake                  | payload
// --------+-----------+----------------------------+---------------------
// item    | in        | start high, busy low       | i_item  (t_item)
// result  | out       | o_valid, one cycle, no stall | o_result (t_result)
//
// One beat is taken every cycle while busy is low; each result passes the
// input register, the product register (16 truncated multipliers in
// parallel) and the result register.
// busy is high only while reset is held; reset clears the valid pipeline.
// The receiver cannot stall, so nothing ever backs up.
//
// Scalar multiply reuses the constant-column multipliers with the scalar
// in place of y's constant coefficient.
// ----------------------------------------------------------------------------
module zomega_ring_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  zora_pkg::t_item   i_item,
    output logic              o_valid,
    output zora_pkg::t_result o_result
);

    logic              w_accept;
    logic              r_in_vld;
    zora_pkg::t_op     r_in_op;
    zora_pkg::t_elem   r_in_x;
    zora_pkg::t_elem   r_in_y;
    zora_pkg::t_coef   r_in_s;
    zora_pkg::t_op     n_in_op;
    zora_pkg::t_elem   n_in_x;
    zora_pkg::t_elem   n_in_y;
    zora_pkg::t_coef   n_in_s;
    logic              w_mid_vld;
    zora_pkg::t_mid    w_mid;
    zora_pkg::t_result w_res;
    logic              r_out_vld;
    zora_pkg::t_result r_out;

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    // unpack and load the incoming beat
    always_comb begin
        n_in_op   = zora_pkg::t_op'(i_item.opcode);
        n_in_x[0] = zora_pkg::f_load(i_item.x_a);
        n_in_x[1] = zora_pkg::f_load(i_item.x_b);
        n_in_x[2] = zora_pkg::f_load(i_item.x_c);
        n_in_x[3] = zora_pkg::f_load(i_item.x_d);
        n_in_y[0] = zora_pkg::f_load(i_item.y_a);
        n_in_y[1] = zora_pkg::f_load(i_item.y_b);
        n_in_y[2] = zora_pkg::f_load(i_item.y_c);
        n_in_y[3] = zora_pkg::f_load(i_item.y_d);
        n_in_s    = zora_pkg::f_load(i_item.scalar);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= w_accept;
        end
        if (w_accept) begin
            r_in_op <= n_in_op;
            r_in_x  <= n_in_x;
            r_in_y  <= n_in_y;
            r_in_s  <= n_in_s;
        end
    end

    zora_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_op    (r_in_op),
        .i_x     (r_in_x),
        .i_y     (r_in_y),
        .i_s     (r_in_s),
        .o_vld   (w_mid_vld),
        .o_mid   (w_mid)
    );

    zora_comb u_comb (
        .i_mid (w_mid),
        .o_res (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_mid_vld;
        end
        r_out <= w_res;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // every accepted beat yields exactly one result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(w_accept, 3))
        else $error("result strobe does not match accepted beat");

    // compare flags are exclusive
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.x_less && o_result.x_equal))
        else $error("x_less and x_equal both set");

    // equal operands subtract to zero
    a_sub_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mid_vld && w_mid.equal && w_mid.op == zora_pkg::OP_SUB) |=>
        (o_result.r_a == '0 && o_result.r_b == '0 &&
         o_result.r_c == '0 && o_result.r_d == '0))
        else $error("x - x is not zero");

endmodule
